FILE: design/dqnp_pkg.sv
`default_nettype none

package dqnp_pkg;

    // Parse phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_LABEL   = 3'd2;
    localparam logic [2:0] PH_TYPE_HI = 3'd3;
    localparam logic [2:0] PH_TYPE_LO = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // Verdict codes
    localparam logic [1:0] VERDICT_A_QUERY     = 2'd0;
    localparam logic [1:0] VERDICT_OTHER_QUERY = 2'd1;
    localparam logic [1:0] VERDICT_INVALID     = 2'd2;

    // Item kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [15:0] NAME_START    = 16'd12;
    localparam logic [15:0] FLAGS_OFFSET  = 16'd2;
    localparam logic [15:0] MIN_LENGTH    = 16'd3;
    localparam logic [15:0] POSITION_MAX  = 16'hFFFF;
    localparam logic [7:0]  DOT_CHAR      = 8'd46;
    localparam logic [7:0]  HEADER_MASK   = 8'hFA;
    localparam logic [7:0]  QTYPE_A_LOW   = 8'd1;

    // Output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
        logic [1:0] verdict;
        logic       last;
    } item_t;

    // Up to two result items per input beat, packed from slot 0 up
    typedef struct packed {
        logic [1:0]      valid;
        item_t [1:0]     item;
    } item_pair_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             can_take;
    } fifo_status_t;

endpackage

`default_nettype wire

FILE: design/dns_query_name_parser.sv
// DNS query question-name parser.
// Slave channel: one datagram byte per beat, in order from offset zero,
// with the total datagram length on every beat and tlast on the final byte.
// Master channel: the question name as characters (tuser = 0), a dot before
// every label after the first, then one verdict beat (tuser = 1, tlast = 1)
// per datagram: 0 A query, 1 other valid query, 2 not a valid query.
// Each input beat yields zero, one or two output beats.
// Path: an accepted byte lands in the input register, the parser works on it
// there and, once the queue has room for a pair, writes its results into a
// four-entry output queue whose head drives the master side directly.
// Throughput: one byte per cycle while the receiver takes one beat per cycle;
// a byte that yields both its final character and the verdict uses two output
// slots, which the queue absorbs. The queue must have room for two results
// before the input register advances.
// Reset: clears the parse state to the start of a datagram and empties the
// input register and the queue. When the receiver stalls, results collect in
// the queue and tready drops once it cannot take another pair; nothing is lost.
`default_nettype none

module dns_query_name_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] packet_length
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] name_char, [9:8] verdict, zero pad
    output logic             m_axis_tuser,   // item_kind
    output logic             m_axis_tlast    // last
);

    logic        stage_valid_reg, stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic [15:0] stage_length_reg;
    logic        stage_last_reg;
    logic        stage_move;
    logic        in_accept;

    dqnp_pkg::item_pair_t   results;
    dqnp_pkg::item_t        out_item;
    dqnp_pkg::fifo_status_t fifo_status;

    // Advance the input register only when the queue can hold a full pair.
    assign stage_move    = stage_valid_reg & fifo_status.can_take;
    assign s_axis_tready = !stage_valid_reg || fifo_status.can_take;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (stage_move)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // Payload: hold while stalled, load on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg   <= s_axis_tdata[7:0];
            stage_length_reg <= s_axis_tdata[23:8];
            stage_last_reg   <= s_axis_tlast;
        end
    end

    dqnp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (stage_move),
        .data_byte     (stage_byte_reg),
        .packet_length (stage_length_reg),
        .last_byte     (stage_last_reg),
        .results       (results)
    );

    dqnp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (stage_move),
        .wr_items (results),
        .pop      (m_axis_tready),
        .rd_item  (out_item),
        .rd_valid (m_axis_tvalid),
        .status   (fifo_status)
    );

    assign m_axis_tdata = {6'd0, out_item.verdict, out_item.name_char};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.count <= dqnp_pkg::CNT_W'(dqnp_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

    // A verdict beat always closes the datagram and carries no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == dqnp_pkg::KIND_VERDICT)
            |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
    else $error("verdict beat malformed");

    // A character beat carries a zero verdict field and no tlast.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == dqnp_pkg::KIND_CHAR)
            |-> (!m_axis_tlast && m_axis_tdata[9:8] == dqnp_pkg::VERDICT_A_QUERY))
    else $error("character beat malformed");

    // A byte held in the input register is not dropped while the queue cannot take a pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !fifo_status.can_take) |=> stage_valid_reg)
    else $error("stalled input byte lost");

endmodule

`default_nettype wire

FILE: design/dqnp_parser.sv
`default_nettype none

module dqnp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        packet_length,
    input  wire logic               last_byte,
    output dqnp_pkg::item_pair_t    results
);

    logic [15:0] byte_position_reg, byte_position_next;
    logic        header_valid_reg, header_valid_next;
    logic [2:0]  parse_phase_reg, parse_phase_next;
    logic [7:0]  label_remaining_reg, label_remaining_next;
    logic        type_high_zero_reg, type_high_zero_next;
    logic        type_low_one_reg, type_low_one_next;

    logic        hv;
    logic [2:0]  phase_c;
    logic [7:0]  rem_c;
    logic        thz_c;
    logic        tlo_c;
    logic        name_valid;
    logic [7:0]  name_char;
    logic [1:0]  verdict;
    logic [16:0] label_end;
    dqnp_pkg::item_t name_item;
    dqnp_pkg::item_t verdict_item;

    assign label_end = {1'b0, byte_position_reg} + {9'd0, data_byte};

    always_comb
    begin
        hv         = header_valid_reg & (packet_length >= dqnp_pkg::MIN_LENGTH);
        phase_c    = parse_phase_reg;
        rem_c      = label_remaining_reg;
        thz_c      = type_high_zero_reg;
        tlo_c      = type_low_one_reg;
        name_valid = 1'b0;
        name_char  = data_byte;

        if (byte_position_reg < packet_length)
        begin
            case (parse_phase_reg)
                dqnp_pkg::PH_HEADER:
                begin
                    if (byte_position_reg == dqnp_pkg::FLAGS_OFFSET &&
                        (data_byte & dqnp_pkg::HEADER_MASK) != 8'd0)
                        hv = 1'b0;
                    if (byte_position_reg == dqnp_pkg::NAME_START - 16'd1)
                        phase_c = dqnp_pkg::PH_LENGTH;
                end
                dqnp_pkg::PH_LENGTH:
                begin
                    // take the label only if it ends inside the packet
                    if (data_byte != 8'd0 && label_end < {1'b0, packet_length})
                    begin
                        if (byte_position_reg != dqnp_pkg::NAME_START && hv)
                        begin
                            name_valid = 1'b1;
                            name_char  = dqnp_pkg::DOT_CHAR;
                        end
                        rem_c   = data_byte;
                        phase_c = dqnp_pkg::PH_LABEL;
                    end
                    else
                    begin
                        phase_c = dqnp_pkg::PH_TYPE_HI;
                    end
                end
                dqnp_pkg::PH_LABEL:
                begin
                    name_valid = hv;
                    rem_c      = label_remaining_reg - 8'd1;
                    if (rem_c == 8'd0)
                        phase_c = dqnp_pkg::PH_LENGTH;
                end
                dqnp_pkg::PH_TYPE_HI:
                begin
                    thz_c   = (data_byte == 8'd0);
                    phase_c = dqnp_pkg::PH_TYPE_LO;
                end
                dqnp_pkg::PH_TYPE_LO:
                begin
                    tlo_c   = (data_byte == dqnp_pkg::QTYPE_A_LOW);
                    phase_c = dqnp_pkg::PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        if (!hv || byte_position_reg < dqnp_pkg::FLAGS_OFFSET)
            verdict = dqnp_pkg::VERDICT_INVALID;
        else if (phase_c == dqnp_pkg::PH_DONE && thz_c && tlo_c)
            verdict = dqnp_pkg::VERDICT_A_QUERY;
        else
            verdict = dqnp_pkg::VERDICT_OTHER_QUERY;
    end

    always_comb
    begin
        name_item.kind         = dqnp_pkg::KIND_CHAR;
        name_item.name_char    = name_char;
        name_item.verdict      = dqnp_pkg::VERDICT_A_QUERY;
        name_item.last         = 1'b0;
        verdict_item.kind      = dqnp_pkg::KIND_VERDICT;
        verdict_item.name_char = 8'd0;
        verdict_item.verdict   = verdict;
        verdict_item.last      = 1'b1;

        if (name_valid)
        begin
            results.valid   = {last_byte, 1'b1};
            results.item[0] = name_item;
            results.item[1] = verdict_item;
        end
        else
        begin
            results.valid   = {1'b0, last_byte};
            results.item[0] = verdict_item;
            results.item[1] = verdict_item;
        end
    end

    always_comb
    begin
        if (last_byte)
        begin
            byte_position_next   = 16'd0;
            header_valid_next    = 1'b1;
            parse_phase_next     = dqnp_pkg::PH_HEADER;
            label_remaining_next = 8'd0;
            type_high_zero_next  = 1'b0;
            type_low_one_next    = 1'b0;
        end
        else
        begin
            byte_position_next   = (byte_position_reg == dqnp_pkg::POSITION_MAX) ?
                                   byte_position_reg : byte_position_reg + 16'd1;
            header_valid_next    = hv;
            parse_phase_next     = phase_c;
            label_remaining_next = rem_c;
            type_high_zero_next  = thz_c;
            type_low_one_next    = tlo_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= 16'd0;
            header_valid_reg    <= 1'b1;
            parse_phase_reg     <= dqnp_pkg::PH_HEADER;
            label_remaining_reg <= 8'd0;
            type_high_zero_reg  <= 1'b0;
            type_low_one_reg    <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg   <= byte_position_next;
            header_valid_reg    <= header_valid_next;
            parse_phase_reg     <= parse_phase_next;
            label_remaining_reg <= label_remaining_next;
            type_high_zero_reg  <= type_high_zero_next;
            type_low_one_reg    <= type_low_one_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dqnp_fifo.sv
`default_nettype none

module dqnp_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire dqnp_pkg::item_pair_t wr_items,
    input  wire logic                 pop,
    output dqnp_pkg::item_t           rd_item,
    output logic                      rd_valid,
    output dqnp_pkg::fifo_status_t    status
);

    dqnp_pkg::item_t mem_reg [dqnp_pkg::FIFO_DEPTH];

    logic [dqnp_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dqnp_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dqnp_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       wr0;
    logic                       wr1;
    logic                       do_pop;
    logic [dqnp_pkg::PTR_W-1:0] wr_ptr_plus1;

    assign wr0          = push & wr_items.valid[0];
    assign wr1          = push & wr_items.valid[1];
    assign do_pop       = pop & rd_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + dqnp_pkg::PTR_W'(1);

    assign rd_valid        = (count_reg != '0);
    assign rd_item         = mem_reg[rd_ptr_reg];
    // leave room for a full pair of results
    assign status.count    = count_reg;
    assign status.can_take = (count_reg <= dqnp_pkg::CNT_W'(dqnp_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dqnp_pkg::PTR_W'(wr0) + dqnp_pkg::PTR_W'(wr1);
        rd_ptr_next = rd_ptr_reg + dqnp_pkg::PTR_W'(do_pop);
        count_next  = count_reg + dqnp_pkg::CNT_W'(wr0) + dqnp_pkg::CNT_W'(wr1)
                      - dqnp_pkg::CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem_reg[wr_ptr_reg] <= wr_items.item[0];
        if (wr1)
            mem_reg[wr_ptr_plus1] <= wr_items.item[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
